/* rtl/assert_macros.svh */
// Assertion macros used by the dual queue ring datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQ_ASSERT(lbl, clk, rst, prop, msg)
`define DQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/dqsr_pkg.sv */
// Package: constants, codes, types and helpers of the dual queue ring
`timescale 1ns / 1ps
package dqsr_pkg;

   localparam int RING_DEPTH  = 32;
   localparam int MAX_RESULTS = 32;
   localparam int ADDR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W       = ADDR_W;
   localparam int IDX_W       = $clog2(MAX_RESULTS);
   localparam int DATA_W      = 32;
   localparam int SIZE_W      = 6;
   localparam int ACT_W       = 2;
   localparam int STAT_W      = 2;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);
   localparam logic [ADDR_W-1:0] HALF_ADDR = ADDR_W'(RING_DEPTH / 2);
   localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(RING_DEPTH);
   localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(RING_DEPTH - 1);

   localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DEQ  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LIST = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [1:0] OUT_ENQ   = 2'd0;
   localparam logic [1:0] OUT_EMPTY = 2'd1;
   localparam logic [1:0] OUT_DEQ   = 2'd2;
   localparam logic [1:0] OUT_LIST  = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       enq_commit;
      logic       deq_commit;
      logic       rd_start;
      logic       rd_next;
      logic       out_load;
      logic [1:0] out_kind;
   } dqsr_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             empty;
      logic             walk_last;
      logic             out_free;
   } dqsr_stat_type;

   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_EXT) begin
         s = s - DEPTH_EXT;
      end
      return s[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
      return (a == LAST_ADDR) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] prev_addr(input logic [ADDR_W-1:0] a);
      return (a == '0) ? LAST_ADDR : a - 1'b1;
   endfunction

endpackage

/* rtl/dqsr_ctrl.sv */
// Controller state machine sequencing enqueue, dequeue and list items
`timescale 1ns / 1ps
module dqsr_ctrl
   import dqsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dqsr_stat_type stat,
   output dqsr_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DEQ  = 2'd2;
   localparam logic [1:0] S_LIST = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.action)
               ACT_ENQ: begin
                  if (stat.out_free) begin
                     cmd.enq_commit = 1'b1;
                     cmd.out_load   = 1'b1;
                     cmd.out_kind   = OUT_ENQ;
                     state_in       = S_IDLE;
                  end
               end
               ACT_DEQ, ACT_LIST: begin
                  if (stat.empty) begin
                     if (stat.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = OUT_EMPTY;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     cmd.rd_start = 1'b1;
                     state_in     = (stat.action == ACT_DEQ) ? S_DEQ : S_LIST;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DEQ: begin
            if (stat.out_free) begin
               cmd.deq_commit = 1'b1;
               cmd.out_load   = 1'b1;
               cmd.out_kind   = OUT_DEQ;
               state_in       = S_IDLE;
            end
         end
         S_LIST: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_LIST;
               if (stat.walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/dqsr_datapath.sv */
// Datapath: ring memory, queue heads and counts, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dqsr_datapath
   import dqsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ACT_W-1:0]         req_action,
   input  logic                     req_queue_sel,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [SIZE_W-1:0]        rsp_queue_size,
   output logic                     rsp_last,
   input  dqsr_cmd_type             cmd,
   output dqsr_stat_type            stat
);

   logic [DATA_W-1:0] ring_ff [RING_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [ACT_W-1:0]  act_ff;
   logic              sel_ff;
   logic [DATA_W-1:0] val_ff;

   logic [ADDR_W-1:0] head_first_ff, head_first_in;
   logic [ADDR_W-1:0] head_second_ff, head_second_in;
   logic [CNT_W-1:0]  count_first_ff, count_first_in;
   logic [CNT_W-1:0]  count_second_ff, count_second_in;

   logic [ADDR_W-1:0] walk_ptr_ff;
   logic [IDX_W-1:0]  walk_idx_ff;

   logic                     rsp_valid_ff;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [SIZE_W-1:0]        rsp_size_ff;
   logic                     rsp_last_ff;

   logic [ADDR_W-1:0] sel_head;
   logic [CNT_W-1:0]  sel_count;
   logic [ADDR_W-1:0] other_head;
   logic [ADDR_W-1:0] enq_slot;
   logic              full;
   logic              enq_ok;
   logic [IDX_W-1:0]  last_idx;
   logic              out_free;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;

   always_comb begin
      sel_head   = sel_ff ? head_second_ff : head_first_ff;
      sel_count  = sel_ff ? count_second_ff : count_first_ff;
      other_head = sel_ff ? head_first_ff : head_second_ff;
      enq_slot   = wrap_add(sel_head, ADDR_W'(sel_count));
      full       = (enq_slot == prev_addr(other_head)) || (enq_slot == other_head) ||
                   (sel_count >= MAX_COUNT);
      enq_ok     = cmd.enq_commit && !full;
      if (32'(sel_count) > MAX_RESULTS) begin
         last_idx = IDX_W'(MAX_RESULTS - 1);
      end else begin
         last_idx = IDX_W'(sel_count - 1'b1);
      end
      out_free = !rsp_valid_ff || rsp_ready;
      rd_en    = cmd.rd_start || cmd.rd_next;
      rd_addr  = cmd.rd_start ? sel_head : next_addr(walk_ptr_ff);
   end

   always_comb begin
      stat.action    = act_ff;
      stat.empty     = (sel_count == '0);
      stat.walk_last = (walk_idx_ff == last_idx);
      stat.out_free  = out_free;
   end

   always_ff @(posedge clock) begin
      if (enq_ok) begin
         ring_ff[enq_slot] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         sel_ff <= req_queue_sel;
         val_ff <= req_value;
      end
      if (rd_en) begin
         walk_ptr_ff <= rd_addr;
      end
      if (cmd.rd_start) begin
         walk_idx_ff <= '0;
      end else if (cmd.rd_next) begin
         walk_idx_ff <= walk_idx_ff + 1'b1;
      end
   end

   always_comb begin
      head_first_in   = head_first_ff;
      head_second_in  = head_second_ff;
      count_first_in  = count_first_ff;
      count_second_in = count_second_ff;
      if (enq_ok) begin
         if (sel_ff) begin
            count_second_in = count_second_ff + 1'b1;
         end else begin
            count_first_in = count_first_ff + 1'b1;
         end
      end
      if (cmd.deq_commit) begin
         if (sel_ff) begin
            head_second_in  = next_addr(head_second_ff);
            count_second_in = count_second_ff - 1'b1;
         end else begin
            head_first_in  = next_addr(head_first_ff);
            count_first_in = count_first_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_first_ff   <= '0;
         head_second_ff  <= HALF_ADDR;
         count_first_ff  <= '0;
         count_second_ff <= '0;
      end else begin
         head_first_ff   <= head_first_in;
         head_second_ff  <= head_second_in;
         count_first_ff  <= count_first_in;
         count_second_ff <= count_second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_kind)
            OUT_ENQ: begin
               rsp_status_ff <= full ? ST_FULL : ST_OK;
               rsp_data_ff   <= '0;
               rsp_size_ff   <= full ? SIZE_W'(sel_count) : SIZE_W'(sel_count + 1'b1);
               rsp_last_ff   <= 1'b1;
            end
            OUT_EMPTY: begin
               rsp_status_ff <= ST_EMPTY;
               rsp_data_ff   <= '0;
               rsp_size_ff   <= '0;
               rsp_last_ff   <= 1'b1;
            end
            OUT_DEQ: begin
               rsp_status_ff <= ST_OK;
               rsp_data_ff   <= rd_data_ff;
               rsp_size_ff   <= SIZE_W'(sel_count - 1'b1);
               rsp_last_ff   <= 1'b1;
            end
            OUT_LIST: begin
               rsp_status_ff <= ST_OK;
               rsp_data_ff   <= rd_data_ff;
               rsp_size_ff   <= SIZE_W'(sel_count);
               rsp_last_ff   <= (walk_idx_ff == last_idx);
            end
            default: begin
               rsp_status_ff <= ST_OK;
               rsp_data_ff   <= '0;
               rsp_size_ff   <= '0;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_queue_size = rsp_size_ff;
   assign rsp_last       = rsp_last_ff;

   `DQ_ASSERT(a_load_free, clock, reset, cmd.out_load |-> out_free, "result overwritten while stalled")
   `DQ_ASSERT(a_deq_nonempty, clock, reset, cmd.deq_commit |-> (sel_count != '0 && act_ff == ACT_DEQ), "dequeue from empty queue")
   `DQ_ASSERT(a_walk_bound, clock, reset, cmd.rd_next |-> (walk_idx_ff != last_idx), "list walk past last element")
   `DQ_ASSERT(a_enq_count, clock, reset, enq_ok |=> (sel_count == $past(sel_count) + 1'b1), "enqueue count not advanced")

endmodule

/* rtl/dual_queue_shared_ring.sv */
// Enqueue and empty results load the result register from the execute state once the
// result register is free; a dequeue result loads from the dequeue state after one
// registered ring read, and a list loads its first element likewise, then one element
// per cycle while rsp_ready holds. Items are handled one at a time; the next item is
// accepted the cycle after its last result is loaded, and an unused code loads none.
// Reset: synchronous; both queues empty, ring contents kept, no clearing pass.
`timescale 1ns / 1ps
module dual_queue_shared_ring
   import dqsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ACT_W-1:0]         req_action,
   input  logic                     req_queue_sel,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [SIZE_W-1:0]        rsp_queue_size,
   output logic                     rsp_last
);

   dqsr_cmd_type  cmd;
   dqsr_stat_type stat;

   dqsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dqsr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_queue_sel  (req_queue_sel),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_queue_size (rsp_queue_size),
      .rsp_last       (rsp_last),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule
